/* hw/rtl/pid_heading_turn_controller_top_macros.svh */
// ----------------------------------------------------------------------------
// pid heading turn controller assertion macros
// shared wrappers for clocked assertions, reset disables checking
// ----------------------------------------------------------------------------
`ifndef PID_HEADING_TURN_CONTROLLER_TOP_MACROS_SVH
`define PID_HEADING_TURN_CONTROLLER_TOP_MACROS_SVH

// condition in the same cycle
`define PHTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phtc assertion failed");

// condition in the following cycle
`define PHTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("phtc assertion failed");

`endif

/* hw/rtl/phtc_pkg.sv */
// ----------------------------------------------------------------------------
// phtc_pkg
// shared types and codes of the pid heading turn controller
// ----------------------------------------------------------------------------
package phtc_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] STATUS_RUN      = 2'd0;
  localparam logic [1:0] STATUS_CONVERGE = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;
  localparam logic [1:0] STATUS_IDLE     = 2'd3;

  localparam logic [2:0] REG_KP       = 3'd0;
  localparam logic [2:0] REG_KI       = 3'd1;
  localparam logic [2:0] REG_KD       = 3'd2;
  localparam logic [2:0] REG_PERIOD   = 3'd3;
  localparam logic [2:0] REG_ERR_TOL  = 3'd4;
  localparam logic [2:0] REG_PWR_TOL  = 3'd5;

  // full power on start, Q8 percent
  localparam logic signed [31:0] START_POWER = 32'sd25600;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] kd_gain;
    logic [9:0]  period_ms;
    logic [14:0] error_tolerance;
    logic [15:0] power_tolerance;
  } cfg_t;

endpackage

/* hw/rtl/phtc_if.sv */
// ----------------------------------------------------------------------------
// phtc channel interfaces
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface phtc_cmd_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] target_angle;
  logic [15:0]        timeout_ms;
  logic signed [15:0] measured_angle;

  modport source (output valid, op, target_angle, timeout_ms, measured_angle,
                  input ready);
  modport sink   (input valid, op, target_angle, timeout_ms, measured_angle,
                  output ready);
endinterface

interface phtc_res_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] power_pct;
  logic [1:0]        status;

  modport source (output valid, power_pct, status, input ready);
  modport sink   (input valid, power_pct, status, output ready);
endinterface

/* hw/rtl/phtc_cfg.sv */
// ----------------------------------------------------------------------------
// phtc_cfg
// apb register bank holding gains, period and tolerances
// ----------------------------------------------------------------------------
module phtc_cfg
  import phtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] reg_sel;
  logic       wr_en;

  assign reg_sel = paddr[4:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain         <= 16'd0;
      cfg.ki_gain         <= 16'd0;
      cfg.kd_gain         <= 16'd0;
      cfg.period_ms       <= 10'd10;
      cfg.error_tolerance <= 15'd205;
      cfg.power_tolerance <= 16'd1280;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_KP:      cfg.kp_gain         <= pwdata[15:0];
        REG_KI:      cfg.ki_gain         <= pwdata[15:0];
        REG_KD:      cfg.kd_gain         <= pwdata[15:0];
        REG_PERIOD:  cfg.period_ms       <= pwdata[9:0];
        REG_ERR_TOL: cfg.error_tolerance <= pwdata[14:0];
        REG_PWR_TOL: cfg.power_tolerance <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KP:      prdata = {16'd0, cfg.kp_gain};
      REG_KI:      prdata = {16'd0, cfg.ki_gain};
      REG_KD:      prdata = {16'd0, cfg.kd_gain};
      REG_PERIOD:  prdata = {22'd0, cfg.period_ms};
      REG_ERR_TOL: prdata = {17'd0, cfg.error_tolerance};
      REG_PWR_TOL: prdata = {16'd0, cfg.power_tolerance};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/phtc_core.sv */
// ----------------------------------------------------------------------------
// phtc_core
// input register, pid update and result register with turn state
// ----------------------------------------------------------------------------
`include "pid_heading_turn_controller_top_macros.svh"

module phtc_core
  import phtc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  phtc_cmd_if.sink  cmd,
  phtc_res_if.source res
);

  // input register
  logic               hold_valid;
  logic               hold_op;
  logic signed [15:0] hold_target;
  logic [15:0]        hold_timeout;
  logic signed [15:0] hold_meas;

  // turn state
  logic signed [15:0] goal_angle;
  logic [15:0]        time_limit;
  logic signed [16:0] prior_error;
  logic signed [31:0] error_sum;
  logic signed [31:0] drive_power;
  logic [15:0]        elapsed_ms;
  logic               running;

  logic signed [15:0] goal_angle_next;
  logic [15:0]        time_limit_next;
  logic signed [16:0] prior_error_next;
  logic signed [31:0] error_sum_next;
  logic signed [31:0] drive_power_next;
  logic [15:0]        elapsed_ms_next;
  logic               running_next;
  logic signed [7:0]  pct_next;
  logic [1:0]         status_next;

  logic advance;
  logic proc;

  // datapath terms
  logic signed [16:0] err;
  logic signed [16:0] start_err;
  logic signed [17:0] deriv;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic signed [33:0] p_kp;
  logic signed [48:0] p_ki;
  logic signed [34:0] p_kd;
  logic signed [50:0] acc;
  logic signed [38:0] acc_floor;
  logic signed [31:0] power_new;
  logic signed [31:0] power_adj;
  logic signed [23:0] pct_quot;
  logic signed [7:0]  pct_clamp;
  logic [16:0]        err_abs;
  logic [31:0]        power_abs;
  logic               converged;
  logic               timed_out;
  logic [16:0]        elapsed_sum;

  assign advance   = !res.valid || res.ready;
  assign cmd.ready = !hold_valid || advance;
  assign proc      = hold_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.ready) begin
      hold_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      hold_op      <= cmd.op;
      hold_target  <= cmd.target_angle;
      hold_timeout <= cmd.timeout_ms;
      hold_meas    <= cmd.measured_angle;
    end
  end

  assign err       = 17'(goal_angle) - 17'(hold_meas);
  assign start_err = 17'(hold_target) - 17'(hold_meas);
  assign deriv     = 18'(err) - 18'(prior_error);
  assign sum_wide  = 33'(error_sum) + 33'(err);

  always_comb begin
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  assign p_kp = 34'(err) * 34'($signed({1'b0, cfg.kp_gain}));
  assign p_ki = 49'(sum_sat) * 49'($signed({1'b0, cfg.ki_gain}));
  assign p_kd = 35'(deriv) * 35'($signed({1'b0, cfg.kd_gain}));
  assign acc  = 51'(p_kp) + 51'(p_ki) + 51'(p_kd);

  // arithmetic shift gives the floor of the q12 division
  assign acc_floor = acc[50:12];

  always_comb begin
    if (acc_floor[38:31] != {8{acc_floor[31]}}) begin
      power_new = acc_floor[38] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      power_new = acc_floor[31:0];
    end
  end

  // truncate towards zero when taking whole percent
  assign power_adj = power_new[31] ? (power_new + 32'sd255) : power_new;
  assign pct_quot  = power_adj[31:8];

  always_comb begin
    if (pct_quot > 24'sd100) begin
      pct_clamp = 8'sd100;
    end else if (pct_quot < -24'sd100) begin
      pct_clamp = -8'sd100;
    end else begin
      pct_clamp = pct_quot[7:0];
    end
  end

  assign err_abs     = prior_error[16] ? 17'(-prior_error) : 17'(prior_error);
  assign power_abs   = drive_power[31] ? 32'(-drive_power) : 32'(drive_power);
  assign converged   = (err_abs <= {2'b00, cfg.error_tolerance}) &&
                       (power_abs <= {16'd0, cfg.power_tolerance});
  assign timed_out   = (time_limit != 16'd0) && (elapsed_ms > time_limit);
  assign elapsed_sum = {1'b0, elapsed_ms} + {7'd0, cfg.period_ms};

  always_comb begin
    goal_angle_next  = goal_angle;
    time_limit_next  = time_limit;
    prior_error_next = prior_error;
    error_sum_next   = error_sum;
    drive_power_next = drive_power;
    elapsed_ms_next  = elapsed_ms;
    running_next     = running;
    pct_next         = 8'sd0;
    status_next      = STATUS_IDLE;
    priority if (hold_op == OP_START) begin
      goal_angle_next  = hold_target;
      time_limit_next  = hold_timeout;
      prior_error_next = start_err;
      error_sum_next   = 32'sd0;
      drive_power_next = START_POWER;
      elapsed_ms_next  = 16'd0;
      running_next     = 1'b1;
      status_next      = STATUS_RUN;
    end else if (!running) begin
      status_next = STATUS_IDLE;
    end else if (converged) begin
      running_next = 1'b0;
      status_next  = STATUS_CONVERGE;
    end else if (timed_out) begin
      running_next = 1'b0;
      status_next  = STATUS_TIMEOUT;
    end else begin
      prior_error_next = err;
      error_sum_next   = sum_sat;
      drive_power_next = power_new;
      elapsed_ms_next  = elapsed_sum[16] ? 16'hffff : elapsed_sum[15:0];
      pct_next         = pct_clamp;
      status_next      = STATUS_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_angle  <= 16'sd0;
      time_limit  <= 16'd0;
      prior_error <= 17'sd0;
      error_sum   <= 32'sd0;
      drive_power <= 32'sd0;
      elapsed_ms  <= 16'd0;
      running     <= 1'b0;
    end else if (proc) begin
      goal_angle  <= goal_angle_next;
      time_limit  <= time_limit_next;
      prior_error <= prior_error_next;
      error_sum   <= error_sum_next;
      drive_power <= drive_power_next;
      elapsed_ms  <= elapsed_ms_next;
      running     <= running_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res.power_pct <= pct_next;
      res.status    <= status_next;
    end
  end

  `PHTC_ASSERT_SAME(a_stopped_zero_power,
    res.valid && (res.status != STATUS_RUN), res.power_pct == 8'sd0)
  `PHTC_ASSERT_SAME(a_power_in_range,
    res.valid, (res.power_pct <= 8'sd100) && (res.power_pct >= -8'sd100))
  `PHTC_ASSERT_NEXT(a_held_item_kept,
    hold_valid && !advance, hold_valid && $stable(hold_meas))
  `PHTC_ASSERT_NEXT(a_start_runs,
    proc && (hold_op == OP_START), running && (res.status == STATUS_RUN))

endmodule

/* hw/rtl/pid_heading_turn_controller_top.sv */
// ----------------------------------------------------------------------------
// pid_heading_turn_controller_top
// pid heading controller: start and tick commands in, drive percent out
// ----------------------------------------------------------------------------
//   channel  dir  kind          payload
//   cmd      in   valid/ready   op, target_angle, timeout_ms, measured_angle
//   res      out  valid/ready   power_pct, status
//   apb      in   apb write/rd  kp, ki, kd, period, error and power tolerance
//
// one transaction per cycle unless res stalls; each command passes the input
// register, then the pid update, then the result register
// rst is synchronous: the controller comes up idle with default settings
// a stalled result holds the input register, cmd ready drops only then
// ----------------------------------------------------------------------------
module pid_heading_turn_controller_top
  import phtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  phtc_cmd_if.sink    cmd,
  phtc_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;

  phtc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phtc_core u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (cmd),
    .res (res)
  );

endmodule

/* tb/tb_pid_heading_turn_controller_top.sv */
// ----------------------------------------------------------------------------
// tb_pid_heading_turn_controller_top
// self-checking bench for the pid heading controller. two short directed tables
// open the run, random turns follow over several register settings, and a
// few constant-error turns, the last with heavy gains, close it. every result
// is compared field by field with a pinned value or a cycle-free model of the controller
// ----------------------------------------------------------------------------
module tb_pid_heading_turn_controller_top
  import phtc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_PCT    = 19;
  localparam int MAX_REPORTS = 10;
  localparam int TURN_ITEMS  = 120;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int SOAK_RISE   = 200;
  localparam int SOAK_FALL   = 40;
  localparam int SOAK_CLIP   = 200;

  localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [7:0] power_pct;
    logic [1:0]        status;
  } turn_result_t;

  typedef struct {
    logic               op;
    logic signed [15:0] target_angle;
    logic [15:0]        timeout_ms;
    logic signed [15:0] measured_angle;
    bit                 pinned;
    turn_result_t       pin;
  } heading_cmd_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  phtc_cmd_if cmd_ch ();
  phtc_res_if res_ch ();

  pid_heading_turn_controller_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // register shadow and turn state of the model
  cfg_t               live_cfg;
  logic signed [15:0] tgt_heading   = '0;
  logic [15:0]        turn_limit_ms = '0;
  logic signed [16:0] last_err      = '0;
  logic signed [31:0] err_integral  = '0;
  logic signed [31:0] power_q8      = '0;
  logic [15:0]        turn_time_ms  = '0;
  bit                 turning       = 1'b0;

  turn_result_t expected_results[$];
  heading_cmd_t cur_cmd;
  bit           steady = 1'b0;

  int fail_count     = 0;
  int cmds_accepted  = 0;
  int starts_seen    = 0;
  int results_seen   = 0;
  int settings_count = 0;
  int cycle_count    = 0;
  int status_seen[4] = '{0, 0, 0, 0};

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > I32_MAX) return 32'sh7fffffff;
    if (v < I32_MIN) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // one command through the controller, returns the result it must produce
  function automatic turn_result_t pid_advance(input heading_cmd_t c);
    turn_result_t r;
    longint       err;
    longint       slope;
    longint       acc;
    longint       t_ms;
    int           pct;
    r.power_pct = '0;
    r.status    = STATUS_RUN;
    if (c.op == OP_START) begin
      tgt_heading   = c.target_angle;
      turn_limit_ms = c.timeout_ms;
      last_err      = 17'(longint'(c.target_angle) - longint'(c.measured_angle));
      err_integral  = '0;
      power_q8      = START_POWER;
      turn_time_ms  = '0;
      turning       = 1'b1;
    end else if (!turning) begin
      r.status = STATUS_IDLE;
    end else if (mag(last_err) <= longint'(live_cfg.error_tolerance) &&
                 mag(power_q8) <= longint'(live_cfg.power_tolerance)) begin
      turning  = 1'b0;
      r.status = STATUS_CONVERGE;
    end else if (turn_limit_ms != 0 && turn_time_ms > turn_limit_ms) begin
      turning  = 1'b0;
      r.status = STATUS_TIMEOUT;
    end else begin
      err          = longint'(tgt_heading) - longint'(c.measured_angle);
      slope        = err - longint'(last_err);
      err_integral = clip32(longint'(err_integral) + err);
      last_err     = 17'(err);
      acc = err * longint'(live_cfg.kp_gain)
          + longint'(err_integral) * longint'(live_cfg.ki_gain)
          + slope * longint'(live_cfg.kd_gain);
      // arithmetic shift gives the floor of the division
      power_q8     = clip32(acc >>> 12);
      t_ms         = longint'(turn_time_ms) + longint'(live_cfg.period_ms);
      turn_time_ms = (t_ms > 65535) ? 16'hffff : 16'(t_ms);
      pct = int'(power_q8) / 256;
      if (pct > 100) pct = 100;
      if (pct < -100) pct = -100;
      r.power_pct = 8'(pct);
    end
    return r;
  endfunction

  function automatic heading_cmd_t make_cmd(input logic op, input logic [15:0] tgt,
                                            input logic [15:0] limit,
                                            input logic [15:0] meas);
    heading_cmd_t c;
    c.op             = op;
    c.target_angle   = tgt;
    c.timeout_ms     = limit;
    c.measured_angle = meas;
    c.pinned         = 1'b0;
    c.pin            = '0;
    return c;
  endfunction

  // a row whose outcome is known without the model: power 0 and a fixed status
  function automatic heading_cmd_t make_pinned(input logic op, input logic [15:0] tgt,
                                               input logic [15:0] limit,
                                               input logic [15:0] meas,
                                               input logic [1:0] st);
    heading_cmd_t c;
    c               = make_cmd(op, tgt, limit, meas);
    c.pinned        = 1'b1;
    c.pin.power_pct = '0;
    c.pin.status    = st;
    return c;
  endfunction

  function automatic logic signed [15:0] pick_angle();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_timeout();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return 16'h0000;
    if (roll < 60) return 16'($urandom_range(1, 300));
    if (roll < 70) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic flag_failure(input string what, input turn_result_t want,
                              input turn_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected power %0d status %0d, got power %0d status %0d",
               $time, what, want.power_pct, want.status, got.power_pct, got.status);
  endtask

  // command channel
  task automatic send_cmd(input heading_cmd_t c);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cur_cmd               = c;
    cmd_ch.valid          <= 1'b1;
    cmd_ch.op             <= c.op;
    cmd_ch.target_angle   <= c.target_angle;
    cmd_ch.timeout_ms     <= c.timeout_ms;
    cmd_ch.measured_angle <= c.measured_angle;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  task automatic run_rows(input heading_cmd_t rows[$]);
    foreach (rows[i]) send_cmd(rows[i]);
  endtask

  // stop offering and let every outstanding result drain
  task automatic settle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KP:      live_cfg.kp_gain         = data[15:0];
      REG_KI:      live_cfg.ki_gain         = data[15:0];
      REG_KD:      live_cfg.kd_gain         = data[15:0];
      REG_PERIOD:  live_cfg.period_ms       = data[9:0];
      REG_ERR_TOL: live_cfg.error_tolerance = data[14:0];
      REG_PWR_TOL: live_cfg.power_tolerance = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_cfg(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kd, input logic [31:0] period,
                             input logic [31:0] etol, input logic [31:0] ptol);
    reg_write(REG_KP, kp);
    reg_write(REG_KI, ki);
    reg_write(REG_KD, kd);
    reg_write(REG_PERIOD, period);
    reg_write(REG_ERR_TOL, etol);
    reg_write(REG_PWR_TOL, ptol);
    settings_count++;
  endtask

  task automatic apply_phase(input int phase);
    case (phase)
      0: program_cfg($urandom_range(0, 512), $urandom_range(0, 64), $urandom_range(0, 512),
                     32'd10, 32'd205, 32'd1280);
      1: program_cfg(32'hffff, 32'hffff, 32'hffff, 32'd1000, 32'h7fff, 32'hffff);
      2: begin
        program_cfg(32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0);
        // unmapped slots must leave every register alone
        reg_write(REG_UNMAPPED_A, $urandom);
        reg_write(REG_UNMAPPED_B, $urandom);
      end
      3: program_cfg($urandom_range(0, 1024), $urandom_range(0, 32), $urandom_range(0, 1024),
                     32'd0, $urandom_range(0, 2000), $urandom_range(0, 8000));
      // all ones: period lands on 1023 and the upper bits are dropped
      4: program_cfg($urandom_range(0, 256), $urandom_range(0, 16), $urandom_range(0, 256),
                     32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      default: program_cfg({16'($urandom), 16'($urandom_range(0, 2048))},
                           {16'($urandom), 16'($urandom_range(0, 128))},
                           {16'($urandom), 16'($urandom_range(0, 2048))},
                           $urandom, $urandom, $urandom);
    endcase
  endtask

  // turns whose heading error mostly decays, with noise and abandoned turns
  task automatic random_turns(input int budget);
    int                 sent;
    int                 gap_err;
    int                 meas_i;
    int                 roll;
    logic signed [15:0] tgt;
    sent = 0;
    while (sent < budget) begin
      tgt    = pick_angle();
      meas_i = pick_angle();
      send_cmd(make_cmd(OP_START, tgt, pick_timeout(), 16'(meas_i)));
      sent++;
      gap_err = int'(tgt) - meas_i;
      repeat ($urandom_range(1, 40)) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          meas_i = pick_angle();
        end else if (roll < 12) begin
          tgt = pick_angle();
          send_cmd(make_cmd(OP_START, tgt, pick_timeout(), 16'(meas_i)));
          sent++;
          gap_err = int'(tgt) - meas_i;
        end else begin
          gap_err = (gap_err * int'($urandom_range(0, 7))) / 8
                  + int'($urandom_range(0, 16)) - 8;
          meas_i  = int'(tgt) - gap_err;
          if (meas_i > 32767) meas_i = 32767;
          if (meas_i < -32768) meas_i = -32768;
        end
        send_cmd(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'(meas_i)));
        sent++;
      end
    end
  endtask

  // constant-error turns: the integral climbs, then a kp offset works against
  // the built-up sum; finally full gains drive the power hard negative
  task automatic integral_soak();
    steady = 1'b1;
    program_cfg(32'd0, 32'd1, 32'd0, 32'd1000, 32'd0, 32'd0);
    send_cmd(make_cmd(OP_START, 16'hffff, 16'h0000, 16'h8000));
    repeat (SOAK_RISE) send_cmd(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h8000));
    settle();
    reg_write(REG_KP, 32'h0000_ffff);
    repeat (SOAK_FALL) send_cmd(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h7fff));
    settle();
    program_cfg(32'hffff, 32'hffff, 32'hffff, 32'd1000, 32'd0, 32'd0);
    send_cmd(make_cmd(OP_START, 16'hffff, 16'h0000, 16'h7fff));
    repeat (SOAK_CLIP) send_cmd(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h7fff));
    settle();
    steady = 1'b0;
  endtask

  // result channel sink, with one long hold-off once traffic is flowing
  initial begin : result_sink
    int hold_left;
    bit held;
    hold_left    = 0;
    held         = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    turn_result_t predicted;
    turn_result_t got;
    turn_result_t want;
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predicted = pid_advance(cur_cmd);
        expected_results.push_back(cur_cmd.pinned ? cur_cmd.pin : predicted);
        cmds_accepted++;
        if (cur_cmd.op == OP_START) starts_seen++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got.power_pct = res_ch.power_pct;
        got.status    = res_ch.status;
        results_seen++;
        status_seen[got.status]++;
        if (expected_results.size() == 0) begin
          flag_failure("result with no command behind it", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.power_pct !== want.power_pct || got.status !== want.status)
            flag_failure("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    heading_cmd_t rows_default[$];
    heading_cmd_t rows_full[$];
    cmd_ch.valid          = 1'b0;
    cmd_ch.op             = OP_TICK;
    cmd_ch.target_angle   = '0;
    cmd_ch.timeout_ms     = '0;
    cmd_ch.measured_angle = '0;
    live_cfg.kp_gain         = 16'd0;
    live_cfg.ki_gain         = 16'd0;
    live_cfg.kd_gain         = 16'd0;
    live_cfg.period_ms       = 10'd10;
    live_cfg.error_tolerance = 15'd205;
    live_cfg.power_tolerance = 16'd1280;

    // reset settings: zero gains, 10 ms period, default tolerances
    rows_default.push_back(make_pinned(OP_TICK, 16'h0000, 16'h0000, 16'h0000, STATUS_IDLE));
    rows_default.push_back(make_pinned(OP_TICK, 16'h0000, 16'h0000, 16'h7fff, STATUS_IDLE));
    rows_default.push_back(make_pinned(OP_START, 16'h7fff, 16'hffff, 16'h8000, STATUS_RUN));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h8000));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h7fff));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
    rows_default.push_back(make_pinned(OP_START, 16'h0000, 16'h0001, 16'h4000, STATUS_RUN));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h4000));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h4000));
    rows_default.push_back(make_pinned(OP_START, 16'h8000, 16'h0000, 16'h7fff, STATUS_RUN));
    rows_default.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h7fff));

    // full gains, zero tolerances: power pinned at both rails, exact convergence
    rows_full.push_back(make_pinned(OP_START, 16'h7fff, 16'h0000, 16'h8000, STATUS_RUN));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h8000));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h7fff));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h8000));
    rows_full.push_back(make_pinned(OP_START, 16'h8000, 16'h0000, 16'h7fff, STATUS_RUN));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h7fff));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h8000));
    rows_full.push_back(make_pinned(OP_START, 16'h0000, 16'h0000, 16'h0000, STATUS_RUN));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h0000));
    rows_full.push_back(make_cmd(OP_TICK, 16'h0000, 16'h0000, 16'h0000));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    run_rows(rows_default);
    settle();
    program_cfg(32'hffff, 32'hffff, 32'hffff, 32'd1000, 32'd0, 32'd0);
    run_rows(rows_full);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      apply_phase(phase);
      steady = (phase == 5);
      random_turns(TURN_ITEMS);
    end
    settle();
    steady = 1'b0;
    integral_soak();

    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("covered %0d commands (%0d turn starts) and %0d results over %0d settings",
             cmds_accepted, starts_seen, results_seen, settings_count);
    $display("soak ticks %0d", SOAK_RISE + SOAK_FALL + SOAK_CLIP);
    $display("outcomes: running %0d, converged %0d, timed out %0d, idle %0d; %0d failures",
             status_seen[STATUS_RUN], status_seen[STATUS_CONVERGE],
             status_seen[STATUS_TIMEOUT], status_seen[STATUS_IDLE], fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
